/* hdl/sfds_pkg.sv */
// shared types, constants and glyph font for the frame store with embedded sync
// depends on nothing; imported by every module of the block
package sfds_pkg;

	// frame geometry
	localparam int LINE_BYTES  = 50;
	localparam int FRAME_LINES = 525;
	localparam int BLOCK_LINES = 16;
	localparam int FRAME_BYTES = LINE_BYTES * FRAME_LINES;

	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int COL_W  = $clog2(LINE_BYTES);
	localparam int LINE_W = $clog2(FRAME_LINES);

	// port field widths
	localparam int KIND_W     = 3;
	localparam int COLF_W     = 6;
	localparam int ROWF_W     = 6;
	localparam int GLYPHF_W   = 6;
	localparam int PIX_W      = 8;
	localparam int HCOL_W     = 6;
	localparam int VLINE_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// sync bits inside a frame byte
	localparam logic [PIX_W-1:0] HSYNC_BIT = 8'h04;
	localparam logic [PIX_W-1:0] VSYNC_BIT = 8'h08;
	localparam logic [PIX_W-1:0] SYNC_MASK = 8'h0C;

	// register reset values
	localparam logic [HCOL_W-1:0]  HS_FIRST_RST = 6'd43;
	localparam logic [HCOL_W-1:0]  HS_LAST_RST  = 6'd49;
	localparam logic [VLINE_W-1:0] VS_FIRST_RST = 10'd490;
	localparam logic [VLINE_W-1:0] VS_LAST_RST  = 10'd491;
	localparam logic [PIX_W-1:0]   PATTERN_RST  = 8'd176;

	// font
	localparam int GLYPH_COUNT = 36;
	localparam int GLYPH_ROWS  = 5;
	localparam int GLYPH_COLS  = 3;
	localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
	localparam int CELL_W      = $clog2(GLYPH_CELLS);
	localparam int GROW_W      = $clog2(GLYPH_ROWS);
	localparam int GCOL_W      = $clog2(GLYPH_COLS);

	// queues
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCC_W       = $clog2(OUT_DEPTH + 1);

	// bit 2 of a row is the leftmost pixel
	localparam logic [GLYPH_COLS-1:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
		'{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd6, 3'd2, 3'd2, 3'd2, 3'd7},
		'{3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
		'{3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
		'{3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd1, 3'd1, 3'd2, 3'd2},
		'{3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
		'{3'd2, 3'd5, 3'd7, 3'd5, 3'd5}, '{3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
		'{3'd3, 3'd4, 3'd4, 3'd4, 3'd3}, '{3'd6, 3'd5, 3'd5, 3'd5, 3'd6},
		'{3'd7, 3'd4, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd4, 3'd7, 3'd4, 3'd4},
		'{3'd7, 3'd4, 3'd5, 3'd5, 3'd7}, '{3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
		'{3'd7, 3'd2, 3'd2, 3'd2, 3'd7}, '{3'd7, 3'd1, 3'd1, 3'd1, 3'd6},
		'{3'd4, 3'd4, 3'd5, 3'd6, 3'd5}, '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
		'{3'd5, 3'd7, 3'd5, 3'd5, 3'd5}, '{3'd6, 3'd5, 3'd5, 3'd5, 3'd5},
		'{3'd2, 3'd5, 3'd5, 3'd5, 3'd2}, '{3'd7, 3'd5, 3'd6, 3'd4, 3'd4},
		'{3'd7, 3'd5, 3'd3, 3'd1, 3'd1}, '{3'd6, 3'd5, 3'd6, 3'd5, 3'd5},
		'{3'd3, 3'd4, 3'd7, 3'd1, 3'd6}, '{3'd7, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd5, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
		'{3'd5, 3'd5, 3'd7, 3'd7, 3'd5}, '{3'd5, 3'd5, 3'd2, 3'd5, 3'd5},
		'{3'd5, 3'd5, 3'd2, 3'd2, 3'd2}, '{3'd7, 3'd1, 3'd2, 3'd4, 3'd7}
	};

	// input kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SCAN  = 3'd0,
		KIND_INIT  = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_PIXEL = 3'd3,
		KIND_GLYPH = 3'd4
	} in_kind_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HS_FIRST = 3'd0,
		CFG_HS_LAST  = 3'd1,
		CFG_VS_FIRST = 3'd2,
		CFG_VS_LAST  = 3'd3,
		CFG_PATTERN  = 3'd4
	} cfg_reg_t;

	// classified commands; a pixel is a one-cell glyph
	typedef enum logic [1:0] {
		OP_SCAN,
		OP_INIT,
		OP_CLEAR,
		OP_DRAW
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                  op;
		logic [COLF_W-1:0]        column;
		logic [ROWF_W-1:0]        block_row;
		logic [GLYPH_CELLS-1:0]   cells;
	} cmd_t;

	typedef struct packed {
		logic [HCOL_W-1:0]  hs_first;
		logic [HCOL_W-1:0]  hs_last;
		logic [VLINE_W-1:0] vs_first;
		logic [VLINE_W-1:0] vs_last;
		logic [PIX_W-1:0]   pattern;
	} cfg_t;

	// cell r*GLYPH_COLS+c set when the glyph has a pixel at row r, column c
	function automatic logic [GLYPH_CELLS-1:0] glyph_cells(input logic [GLYPH_IDX_W-1:0] g);
		logic [GLYPH_CELLS-1:0] m;
		m = '0;
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			for (int c = 0; c < GLYPH_COLS; c++) begin
				m[r*GLYPH_COLS+c] = FONT_ROM[g][r][GLYPH_COLS-1-c];
			end
		end
		return m;
	endfunction

endpackage

/* hdl/sfds_front.sv */
// front end: accepts requests, drops no-op requests, turns the rest into commands
// depends on sfds_pkg
module sfds_front import sfds_pkg::*; (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [COLF_W-1:0]   column,
	input  logic [ROWF_W-1:0]   block_row,
	input  logic [GLYPHF_W-1:0] glyph,
	input  logic                q_full,
	input  logic                wiping,
	output logic                q_push,
	output cmd_t                q_cmd
);

	logic keep;

	always_comb begin
		keep            = 1'b0;
		q_cmd.op        = OP_SCAN;
		q_cmd.column    = column;
		q_cmd.block_row = block_row;
		q_cmd.cells     = '0;
		unique case (kind)
			KIND_SCAN: begin
				keep = 1'b1;
			end
			KIND_INIT: begin
				keep     = 1'b1;
				q_cmd.op = OP_INIT;
			end
			KIND_CLEAR: begin
				keep     = 1'b1;
				q_cmd.op = OP_CLEAR;
			end
			KIND_PIXEL: begin
				keep        = 1'b1;
				q_cmd.op    = OP_DRAW;
				q_cmd.cells = GLYPH_CELLS'(1);
			end
			KIND_GLYPH: begin
				// indexes past the font draw nothing
				if (GLYPH_IDX_W'(glyph) < GLYPH_IDX_W'(GLYPH_COUNT)) begin
					keep        = 1'b1;
					q_cmd.op    = OP_DRAW;
					q_cmd.cells = glyph_cells(GLYPH_IDX_W'(glyph));
				end
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = q_full | wiping;
	assign q_push   = in_valid & ~in_stall & keep;

endmodule

/* hdl/sfds_queue.sv */
// short command queue between the front end and the drawing engine
// depends on sfds_pkg
module sfds_queue import sfds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	assign pop_cmd = slot_q[rd_q];
	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);

endmodule

/* hdl/sfds_back.sv */
// drawing engine: frame memory, address sequencer, read-modify-write stage, scan fifo
// depends on sfds_pkg
module sfds_back import sfds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	output logic             wiping,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] pin_byte
);

	localparam int CCMP_W  = ((COLF_W + 1) > (COL_W + 1)) ? (COLF_W + 1) : (COL_W + 1);
	localparam int ROWV_W  = ROWF_W + 1;
	localparam int LINE0_W = ROWV_W + $clog2(BLOCK_LINES + 1);
	localparam int K_W     = $clog2(BLOCK_LINES + 1);
	localparam int HC_W    = (COL_W > HCOL_W) ? COL_W : HCOL_W;
	localparam int VC_W    = (LINE_W > VLINE_W) ? LINE_W : VLINE_W;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_WALK,
		ST_CELL,
		ST_BLOCK
	} state_t;

	state_t                 state_q;
	cmd_op_t                op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [ADDR_W-1:0]      scan_ptr_q;
	logic [COL_W-1:0]       wcol_q;
	logic [LINE_W-1:0]      wline_q;
	logic [LINE0_W-1:0]     line_q;
	logic [K_W-1:0]         k_q;
	logic [GLYPH_CELLS-1:0] cells_q;
	logic [CELL_W-1:0]      cell_q;
	logic [GROW_W-1:0]      r_q;
	logic [GCOL_W-1:0]      c_q;
	logic [COLF_W-1:0]      col_q;
	logic [ROWF_W-1:0]      brow_q;

	// read-modify-write stage
	logic                   rmw_s1;
	logic                   scan_s1;
	cmd_op_t                op_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic                   hs_s1;
	logic                   vs_s1;

	// frame memory
	logic [PIX_W-1:0]       mem [FRAME_BYTES];
	logic [PIX_W-1:0]       rd_q;
	logic                   we;
	logic [ADDR_W-1:0]      wa;
	logic [PIX_W-1:0]       wd;

	// scan result fifo
	logic [PIX_W-1:0]       ofifo_q [OUT_DEPTH];
	logic [OPTR_W-1:0]      owr_q;
	logic [OPTR_W-1:0]      ord_q;
	logic [OCC_W-1:0]       occ_q;
	logic                   opop;

	// issue side
	logic                   issue_rmw;
	logic                   issue_scan;
	logic [ADDR_W-1:0]      iss_addr;
	logic                   iss_hs;
	logic                   iss_vs;
	logic                   room;

	// cell setup
	logic [CCMP_W-1:0]      ccol;
	logic [ROWV_W-1:0]      rowv;
	logic [LINE0_W-1:0]     line0;
	logic                   cell_hit;
	logic                   cell_last;
	logic                   blk_done;
	logic [ADDR_W-1:0]      start_addr;

	assign room = ((OCC_W+1)'(occ_q) + (OCC_W+1)'(scan_s1)) < (OCC_W+1)'(OUT_DEPTH);

	assign ccol       = CCMP_W'(col_q) + CCMP_W'(c_q);
	assign rowv       = ROWV_W'(brow_q) + ROWV_W'(r_q);
	assign line0      = LINE0_W'(rowv) * LINE0_W'(BLOCK_LINES);
	assign cell_hit   = cells_q[cell_q] && (ccol < CCMP_W'(LINE_BYTES))
	                    && (line0 < LINE0_W'(FRAME_LINES));
	assign start_addr = ADDR_W'(line0[LINE_W-1:0]) * ADDR_W'(LINE_BYTES) + ADDR_W'(ccol);
	assign cell_last  = (cell_q == CELL_W'(GLYPH_CELLS - 1));
	assign blk_done   = (k_q == K_W'(BLOCK_LINES - 1))
	                    || (line_q >= LINE0_W'(FRAME_LINES - 1));

	always_comb begin
		issue_rmw  = 1'b0;
		issue_scan = 1'b0;
		iss_addr   = addr_q;
		iss_hs     = 1'b0;
		iss_vs     = 1'b0;
		q_pop      = 1'b0;
		unique case (state_q)
			ST_WIPE: begin
				iss_addr = addr_q;
			end
			ST_IDLE: begin
				// wait for the last write so every read sees it
				if (!q_empty && !rmw_s1) begin
					if (q_cmd.op == OP_SCAN) begin
						if (room) begin
							q_pop      = 1'b1;
							issue_scan = 1'b1;
							iss_addr   = scan_ptr_q;
						end
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			ST_WALK: begin
				issue_rmw = 1'b1;
				iss_hs    = (HC_W'(wcol_q) >= HC_W'(cfg.hs_first))
				            && (HC_W'(wcol_q) <= HC_W'(cfg.hs_last));
				iss_vs    = (VC_W'(wline_q) >= VC_W'(cfg.vs_first))
				            && (VC_W'(wline_q) <= VC_W'(cfg.vs_last));
			end
			ST_CELL: begin
				iss_addr = addr_q;
			end
			ST_BLOCK: begin
				issue_rmw = 1'b1;
			end
			default: begin
				iss_addr = addr_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_WIPE;
			op_q       <= OP_SCAN;
			addr_q     <= '0;
			scan_ptr_q <= '0;
			wcol_q     <= '0;
			wline_q    <= '0;
			line_q     <= '0;
			k_q        <= '0;
			cells_q    <= '0;
			cell_q     <= '0;
			r_q        <= '0;
			c_q        <= '0;
			col_q      <= '0;
			brow_q     <= '0;
			rmw_s1     <= 1'b0;
			scan_s1    <= 1'b0;
			op_s1      <= OP_SCAN;
			addr_s1    <= '0;
			hs_s1      <= 1'b0;
			vs_s1      <= 1'b0;
		end else begin
			rmw_s1  <= issue_rmw;
			scan_s1 <= issue_scan;
			op_s1   <= op_q;
			addr_s1 <= iss_addr;
			hs_s1   <= iss_hs;
			vs_s1   <= iss_vs;
			unique case (state_q)
				ST_WIPE: begin
					if (addr_q == ADDR_W'(FRAME_BYTES - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (issue_scan) begin
						if (scan_ptr_q == ADDR_W'(FRAME_BYTES - 1)) begin
							scan_ptr_q <= '0;
						end else begin
							scan_ptr_q <= scan_ptr_q + ADDR_W'(1);
						end
					end else if (q_pop) begin
						op_q    <= q_cmd.op;
						addr_q  <= '0;
						wcol_q  <= '0;
						wline_q <= '0;
						cells_q <= q_cmd.cells;
						cell_q  <= '0;
						r_q     <= '0;
						c_q     <= '0;
						col_q   <= q_cmd.column;
						brow_q  <= q_cmd.block_row;
						state_q <= (q_cmd.op == OP_DRAW) ? ST_CELL : ST_WALK;
					end
				end
				ST_WALK: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (wcol_q == COL_W'(LINE_BYTES - 1)) begin
						wcol_q  <= '0;
						wline_q <= wline_q + LINE_W'(1);
					end else begin
						wcol_q <= wcol_q + COL_W'(1);
					end
					if (addr_q == ADDR_W'(FRAME_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CELL: begin
					if (cell_hit) begin
						addr_q  <= start_addr;
						line_q  <= line0;
						k_q     <= '0;
						state_q <= ST_BLOCK;
					end else if (cell_last) begin
						state_q <= ST_IDLE;
					end else begin
						cell_q <= cell_q + CELL_W'(1);
						if (c_q == GCOL_W'(GLYPH_COLS - 1)) begin
							c_q <= '0;
							r_q <= r_q + GROW_W'(1);
						end else begin
							c_q <= c_q + GCOL_W'(1);
						end
					end
				end
				ST_BLOCK: begin
					addr_q <= addr_q + ADDR_W'(LINE_BYTES);
					line_q <= line_q + LINE0_W'(1);
					k_q    <= k_q + K_W'(1);
					if (blk_done) begin
						if (cell_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_CELL;
							cell_q  <= cell_q + CELL_W'(1);
							if (c_q == GCOL_W'(GLYPH_COLS - 1)) begin
								c_q <= '0;
								r_q <= r_q + GROW_W'(1);
							end else begin
								c_q <= c_q + GCOL_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign wiping = (state_q == ST_WIPE);

	// write port: reset wipe, else the modify step
	always_comb begin
		we = 1'b0;
		wa = addr_s1;
		wd = rd_q;
		if (state_q == ST_WIPE) begin
			we = 1'b1;
			wa = addr_q;
			wd = '0;
		end else if (rmw_s1) begin
			we = 1'b1;
			unique case (op_s1)
				OP_INIT:  wd = rd_q | (hs_s1 ? HSYNC_BIT : '0) | (vs_s1 ? VSYNC_BIT : '0);
				OP_CLEAR: wd = rd_q & SYNC_MASK;
				OP_DRAW:  wd = rd_q ^ cfg.pattern;
				default:  wd = rd_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[iss_addr];
	end

	// scan result fifo
	assign opop      = out_valid & ~out_stall;
	assign out_valid = (occ_q != '0);
	assign pin_byte  = ofifo_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			occ_q <= '0;
		end else begin
			if (scan_s1) begin
				owr_q <= owr_q + OPTR_W'(1);
			end
			if (opop) begin
				ord_q <= ord_q + OPTR_W'(1);
			end
			if (scan_s1 && !opop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (opop && !scan_s1) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			ofifo_q[owr_q] <= rd_q;
		end
	end

	// scan data never arrives at a full fifo
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		scan_s1 |-> (occ_q < OCC_W'(OUT_DEPTH)))
		else $error("scan result fifo overflow");

	// the reset wipe runs alone
	a_wipe_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WIPE) |-> (!rmw_s1 && !scan_s1 && !q_pop))
		else $error("memory access during reset wipe");

	// commands are taken only with the write stage drained
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ((state_q == ST_IDLE) && !rmw_s1 && !q_empty))
		else $error("command taken while engine busy");

	// modify writes stay inside the frame
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rmw_s1 |-> (addr_s1 < ADDR_W'(FRAME_BYTES)))
		else $error("write outside frame");

endmodule

/* hdl/sync_framebuffer_draw_scanout.sv */
// top level of the byte frame store with embedded sync bits, drawing and scan-out
// depends on sfds_pkg, sfds_front, sfds_queue, sfds_back
//
// Byte frame of 525 lines by 50 column bytes, bit 2 of each byte horizontal sync and bit 3
// vertical sync. A request on the input channel is one of: scan tick (returns the byte at
// the scan pointer on pin_byte and advances the pointer, wrapping at the frame end), init
// sync (ORs the sync bits over the configured column and line ranges), clear (keeps only the
// sync bits), toggle pixel (XORs pixel_pattern into 16 lines of one column) and toggle glyph
// (toggles a 3x5 font glyph, one 16-line block per set pixel). Other kinds and glyph indexes
// past the font are taken and do nothing; bytes outside the frame are never written. After
// reset the frame memory is swept to zero, one byte a cycle; in_stall is high during that
// pass, while configuration writes are taken as ever. The front end sorts requests into a
// four-entry command queue, so requests are taken while the engine is busy until the queue
// fills. The engine has one read and one write port on the frame memory and issues at most
// one byte access per cycle: scan ticks issue one a cycle while the output fifo has room,
// each result passing through the memory read register and the output fifo to pin_byte;
// init and clear walk every byte of the frame; a pixel toggle runs as a one-cell glyph; a
// glyph steps through its 15 cells and rewrites a block of up to 16 lines per set pixel. A
// command that follows a rewrite waits in the idle state until the last write has landed.
// Scan results sit in a four-entry output fifo; out_stall holds the engine only once a scan
// tick at the head of the queue finds no room in that fifo.
module sync_framebuffer_draw_scanout import sfds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [COLF_W-1:0]     column,
	input  logic [ROWF_W-1:0]     block_row,
	input  logic [GLYPHF_W-1:0]   glyph,
	// scan result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pin_byte,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic wiping;

	// registers always accept; the user must write them only while the block is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hs_first <= HS_FIRST_RST;
			cfg_q.hs_last  <= HS_LAST_RST;
			cfg_q.vs_first <= VS_FIRST_RST;
			cfg_q.vs_last  <= VS_LAST_RST;
			cfg_q.pattern  <= PATTERN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HS_FIRST: cfg_q.hs_first <= cfg_data[HCOL_W-1:0];
				CFG_HS_LAST:  cfg_q.hs_last  <= cfg_data[HCOL_W-1:0];
				CFG_VS_FIRST: cfg_q.vs_first <= cfg_data[VLINE_W-1:0];
				CFG_VS_LAST:  cfg_q.vs_last  <= cfg_data[VLINE_W-1:0];
				CFG_PATTERN:  cfg_q.pattern  <= cfg_data[PIX_W-1:0];
				default: begin
					// writes past the register list are ignored
				end
			endcase
		end
	end

	// request classification
	sfds_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.column    (column),
		.block_row (block_row),
		.glyph     (glyph),
		.q_full    (q_full),
		.wiping    (wiping),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// command queue decouples request intake from the engine
	sfds_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// frame memory, sequencer and scan output
	sfds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.wiping    (wiping),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pin_byte  (pin_byte)
	);

endmodule
